// ----- rtl/frt_pkg.sv -----
// ----------------------------------------------------------------------------
// frt_pkg
// Shared types and constants for the four-channel reload timer.
// ----------------------------------------------------------------------------
package frt_pkg;

  localparam int NUM_TIMERS_DEF = 4;   // default number of timer channels
  localparam int SLOTS          = 4;   // timers reachable through reg_index
  localparam int MASK_W         = 4;   // width of the overflow and irq masks
  localparam int COUNT_W        = 16;  // counter, reload and control width
  localparam int PSC_W          = 10;  // prescale accumulator width
  localparam int STEP_W         = PSC_W + 1;  // counter steps of one tick
  localparam int FX_STEPS       = PSC_W;      // remainder steps in the fix-up
  localparam int FX_CNT_W       = $clog2(FX_STEPS + 1);

  // Control word bit positions.
  localparam int CTRL_ENABLE_BIT  = 7;
  localparam int CTRL_IRQ_BIT     = 6;
  localparam int CTRL_CASCADE_BIT = 2;

  localparam logic [COUNT_W:0] COUNT_SPAN = {1'b1, {COUNT_W{1'b0}}};

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PSC_1    = 2'd0,
    PSC_64   = 2'd1,
    PSC_256  = 2'd2,
    PSC_1024 = 2'd3
  } psc_sel_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  reg_index;
    logic [15:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [15:0]       read_data;
    logic [MASK_W-1:0] overflow_mask;
    logic [MASK_W-1:0] irq_mask;
  } out_item_t;

  // Request to one timer channel, already qualified by the pipeline advance.
  typedef struct packed {
    logic               tick;
    logic               wr_reload;
    logic               wr_ctrl;
    logic [COUNT_W-1:0] data;
  } tmr_cmd_t;

  // Status of one timer channel.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] ctrl;
    logic               ovf;
    logic               irq;
    logic               busy;
  } tmr_stat_t;

endpackage

// ----- rtl/frt_timer.sv -----
// ----------------------------------------------------------------------------
// frt_timer
// One timer channel: prescaler, up-counter with reload, register writes and
// a short remainder sequencer for ticks that wrap through reload repeatedly.
// ----------------------------------------------------------------------------
module frt_timer (
  input  logic             clk,
  input  logic             rst_n,
  input  frt_pkg::tmr_cmd_t  cmd,
  output frt_pkg::tmr_stat_t stat
);
  import frt_pkg::*;

  logic [COUNT_W-1:0]  count_r,  count_nxt;
  logic [COUNT_W-1:0]  reload_r, reload_nxt;
  logic [COUNT_W-1:0]  ctrl_r,   ctrl_nxt;
  logic [PSC_W-1:0]    psc_r,    psc_nxt;
  logic                fx_busy_r, fx_busy_nxt;
  logic [FX_CNT_W-1:0] fx_cnt_r,  fx_cnt_nxt;
  logic [PSC_W-1:0]    fx_div_r,  fx_div_nxt;
  logic [PSC_W-1:0]    fx_rem_r,  fx_rem_nxt;
  logic [PSC_W-1:0]    fx_per_r,  fx_per_nxt;

  logic [STEP_W-1:0]  acc;
  logic [STEP_W-1:0]  steps;
  logic [PSC_W-1:0]   psc_new;
  logic [COUNT_W:0]   to_wrap;
  logic [COUNT_W:0]   diff;
  logic [PSC_W-1:0]   rest;
  logic [COUNT_W:0]   period;
  logic               run;
  logic               wrap;
  logic               more;
  logic [PSC_W:0]     fx_trial;
  logic [PSC_W-1:0]   fx_rem_step;

  assign acc = {1'b0, psc_r} + STEP_W'(1);

  always_comb begin
    unique case (psc_sel_t'(ctrl_r[1:0]))
      PSC_1: begin
        steps   = acc;
        psc_new = '0;
      end
      PSC_64: begin
        steps   = acc >> 6;
        psc_new = {4'b0, acc[5:0]};
      end
      PSC_256: begin
        steps   = acc >> 8;
        psc_new = {2'b0, acc[7:0]};
      end
      PSC_1024: begin
        steps   = acc >> 10;
        psc_new = acc[9:0];
      end
      default: begin
        steps   = '0;
        psc_new = psc_r;
      end
    endcase
  end

  assign run     = cmd.tick && ctrl_r[CTRL_ENABLE_BIT] && !ctrl_r[CTRL_CASCADE_BIT];
  assign to_wrap = COUNT_SPAN - {1'b0, count_r};
  assign wrap    = run && ({{(COUNT_W + 1 - STEP_W){1'b0}}, steps} >= to_wrap);
  assign diff    = {{(COUNT_W + 1 - STEP_W){1'b0}}, steps} - to_wrap;
  assign rest    = diff[PSC_W-1:0];
  assign period  = COUNT_SPAN - {1'b0, reload_r};
  assign more    = wrap && ({{(COUNT_W + 1 - PSC_W){1'b0}}, rest} >= period);

  // One restoring remainder step against the reload period.
  assign fx_trial    = {fx_rem_r, fx_div_r[PSC_W-1]};
  assign fx_rem_step = (fx_trial >= {1'b0, fx_per_r}) ?
                       PSC_W'(fx_trial - {1'b0, fx_per_r}) : fx_trial[PSC_W-1:0];

  always_comb begin
    count_nxt   = count_r;
    reload_nxt  = reload_r;
    ctrl_nxt    = ctrl_r;
    psc_nxt     = psc_r;
    fx_busy_nxt = fx_busy_r;
    fx_cnt_nxt  = fx_cnt_r;
    fx_div_nxt  = fx_div_r;
    fx_rem_nxt  = fx_rem_r;
    fx_per_nxt  = fx_per_r;
    if (fx_busy_r) begin
      fx_rem_nxt = fx_rem_step;
      fx_div_nxt = fx_div_r << 1;
      fx_cnt_nxt = fx_cnt_r - FX_CNT_W'(1);
      if (fx_cnt_r == FX_CNT_W'(1)) begin
        fx_busy_nxt = 1'b0;
        count_nxt   = reload_r + {{(COUNT_W - PSC_W){1'b0}}, fx_rem_step};
      end
    end else if (run) begin
      psc_nxt = psc_new;
      if (!wrap) begin
        count_nxt = count_r + {{(COUNT_W - STEP_W){1'b0}}, steps};
      end else if (!more) begin
        count_nxt = reload_r + {{(COUNT_W - PSC_W){1'b0}}, rest};
      end else begin
        // The counter wraps through reload again; settle the remainder
        // of the leftover steps over the reload period bit by bit.
        count_nxt   = reload_r;
        fx_busy_nxt = 1'b1;
        fx_cnt_nxt  = FX_CNT_W'(FX_STEPS);
        fx_div_nxt  = rest;
        fx_rem_nxt  = '0;
        fx_per_nxt  = period[PSC_W-1:0];
      end
    end else if (cmd.wr_reload) begin
      reload_nxt = cmd.data;
    end else if (cmd.wr_ctrl) begin
      ctrl_nxt = cmd.data;
      if (!ctrl_r[CTRL_ENABLE_BIT] && cmd.data[CTRL_ENABLE_BIT]) begin
        count_nxt = reload_r;
        psc_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      reload_r  <= '0;
      ctrl_r    <= '0;
      psc_r     <= '0;
      fx_busy_r <= 1'b0;
      fx_cnt_r  <= '0;
    end else begin
      count_r   <= count_nxt;
      reload_r  <= reload_nxt;
      ctrl_r    <= ctrl_nxt;
      psc_r     <= psc_nxt;
      fx_busy_r <= fx_busy_nxt;
      fx_cnt_r  <= fx_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fx_div_r <= fx_div_nxt;
    fx_rem_r <= fx_rem_nxt;
    fx_per_r <= fx_per_nxt;
  end

  assign stat.count = count_r;
  assign stat.ctrl  = ctrl_r;
  assign stat.ovf   = wrap;
  assign stat.irq   = wrap && ctrl_r[CTRL_IRQ_BIT];
  assign stat.busy  = fx_busy_r;

endmodule

// ----- rtl/four_channel_reload_timer.sv -----
// A request passes through the input stage, then the result register, to reach out_data.
// Throughput: one request per cycle unless a held result is not taken or a channel is busy, set
// by the single input stage feeding the result register. A tick whose leftover prescaler steps
// wrap a timer through reload more than once holds the input stage while each channel's remainder
// sequencer settles. Reset (rst_n low, synchronous) clears all counters, reloads, control
// words and prescalers, and empties both pipeline registers.
// ----------------------------------------------------------------------------
// four_channel_reload_timer
// Prescaled 16-bit up-counting timers with reload, driven by at most one request per
// clock: a tick, a register write, a register read or a no-op.
// ----------------------------------------------------------------------------
module four_channel_reload_timer #(
  parameter int NUM_TIMERS = frt_pkg::NUM_TIMERS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  frt_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output frt_pkg::out_item_t out_data
);
  import frt_pkg::*;

  // Input stage: holds the request that is being worked on.
  logic      stage_valid_r, stage_valid_nxt;
  in_item_t  stage_r,       stage_nxt;
  // Result register: holds the finished result until the consumer takes it.
  logic      out_valid_r,   out_valid_nxt;
  out_item_t out_r,         out_nxt;

  logic      advance;
  logic      any_busy;
  logic      out_free;
  logic [1:0] sel;
  logic       ctrl_slot;

  tmr_cmd_t  cmd  [NUM_TIMERS];
  tmr_stat_t stat [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] busy_vec;

  // Per-slot views of the addressable timers; slots beyond NUM_TIMERS read zero.
  logic [COUNT_W-1:0] slot_count [SLOTS];
  logic [COUNT_W-1:0] slot_ctrl  [SLOTS];
  logic [MASK_W-1:0]  ovf_mask;
  logic [MASK_W-1:0]  irq_mask;

  assign sel       = stage_r.reg_index[2:1];
  assign ctrl_slot = stage_r.reg_index[0];

  // The request in the input stage completes when the result register can take
  // its result and no channel is still settling a multi-wrap tick.
  assign any_busy = |busy_vec;
  assign out_free = !out_valid_r || out_ready;
  assign advance  = stage_valid_r && out_free && !any_busy;
  assign in_ready = !stage_valid_r || advance;

  for (genvar t = 0; t < NUM_TIMERS; t++) begin : g_tmr
    logic hit;
    if (t < SLOTS) begin : g_addr
      assign hit = (sel == 2'(t));
    end else begin : g_noaddr
      // Timers past the register map cannot be addressed.
      assign hit = 1'b0;
    end

    assign cmd[t].tick      = advance && (stage_r.op == OP_TICK);
    assign cmd[t].wr_reload = advance && (stage_r.op == OP_WRITE) && hit && !ctrl_slot;
    assign cmd[t].wr_ctrl   = advance && (stage_r.op == OP_WRITE) && hit &&  ctrl_slot;
    assign cmd[t].data      = stage_r.write_data;

    frt_timer u_timer (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd[t]),
      .stat  (stat[t])
    );

    assign busy_vec[t] = stat[t].busy;
  end

  for (genvar s = 0; s < SLOTS; s++) begin : g_slot
    if (s < NUM_TIMERS) begin : g_live
      assign slot_count[s] = stat[s].count;
      assign slot_ctrl[s]  = stat[s].ctrl;
      assign ovf_mask[s]   = stat[s].ovf;
      assign irq_mask[s]   = stat[s].irq;
    end else begin : g_empty
      assign slot_count[s] = '0;
      assign slot_ctrl[s]  = '0;
      assign ovf_mask[s]   = 1'b0;
      assign irq_mask[s]   = 1'b0;
    end
  end

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    stage_nxt       = stage_r;
    out_valid_nxt   = out_valid_r;
    out_nxt         = out_r;

    if (in_valid && in_ready) begin
      stage_valid_nxt = 1'b1;
      stage_nxt       = in_data;
    end else if (advance) begin
      stage_valid_nxt = 1'b0;
    end

    if (advance) begin
      // Masks are only raised by ticks; the channels report no wrap otherwise.
      out_valid_nxt         = 1'b1;
      out_nxt.overflow_mask = ovf_mask;
      out_nxt.irq_mask      = irq_mask;
      out_nxt.read_data     = '0;
      if (stage_r.op == OP_READ) begin
        out_nxt.read_data = ctrl_slot ? slot_ctrl[sel] : slot_count[sel];
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/frt_checker.sv -----
// ----------------------------------------------------------------------------
// frt_checker
// Port-level checks for the four-channel reload timer, bound to the top level.
// ----------------------------------------------------------------------------
module frt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input frt_pkg::out_item_t out_data
);
  import frt_pkg::*;

  // A result that waits keeps its place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A result that waits keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  // An interrupt bit is only raised together with its overflow bit.
  a_irq_in_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.irq_mask & ~out_data.overflow_mask) == '0))
    else $error("interrupt without overflow");

  // A result comes from either a read or a tick, never from both.
  a_read_or_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.read_data == '0) || (out_data.overflow_mask == '0))
    else $error("read data and overflow in one result");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind four_channel_reload_timer frt_checker u_frt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- tb/sv/four_channel_reload_timer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_channel_reload_timer_test
// Self-checking bench for the four-channel reload timer. Each accepted
// request (tick, register write, register read, no-op) is run through an
// in-bench copy of the timer bank. The expected response is queued and then
// compared field by field with what comes out of the block. Both channels
// are throttled at random in several phases.
// ----------------------------------------------------------------------------
module four_channel_reload_timer_test;
  import frt_pkg::*;

  localparam int          TIMERS      = NUM_TIMERS_DEF;
  localparam logic        SLOT_COUNT  = 1'b0;   // even slot: counter / reload
  localparam logic        SLOT_CTRL   = 1'b1;   // odd slot: control word
  localparam int unsigned COUNT_RANGE = 1 << COUNT_W;
  localparam int unsigned STALL_LIMIT = 4000;   // cycles with no handshake at all
  localparam int unsigned TAIL_CYCLES = 16;     // margin for the result register and a fix-up still settling
  localparam int unsigned PHASE_ITEMS = 250;

  // Timer bank shadow plus the queue of responses it still owes.
  class timer_result_board;
    logic [COUNT_W-1:0] counter      [TIMERS];
    logic [COUNT_W-1:0] reload       [TIMERS];
    logic [COUNT_W-1:0] control      [TIMERS];
    logic [PSC_W-1:0]   prescale_acc [TIMERS];
    out_item_t          owed_responses[$];
    int unsigned        mismatch_count;
    int unsigned        response_index;

    function new();
      for (int t = 0; t < TIMERS; t++) begin
        counter[t]      = '0;
        reload[t]       = '0;
        control[t]      = '0;
        prescale_acc[t] = '0;
      end
      mismatch_count = 0;
      response_index = 0;
    endfunction

    // Apply one accepted request to the shadow and queue the response it implies.
    function void note_request(in_item_t req);
      out_item_t          rsp;
      int unsigned        tmr, divisor, acc, steps, room;
      logic [COUNT_W-1:0] ctl, old_ctl;
      rsp = '0;
      tmr = req.reg_index >> 1;
      case (req.op)
        OP_TICK: begin
          for (int t = 0; t < TIMERS; t++) begin
            ctl = control[t];
            if (ctl[CTRL_ENABLE_BIT] && !ctl[CTRL_CASCADE_BIT]) begin
              case (psc_sel_t'(ctl[1:0]))
                PSC_1:   divisor = 1;
                PSC_64:  divisor = 64;
                PSC_256: divisor = 256;
                default: divisor = 1024;
              endcase
              acc = prescale_acc[t] + 1;
              steps = acc / divisor;
              prescale_acc[t] = PSC_W'(acc % divisor);
              // A large step count after a divisor change can wrap more than once.
              while (steps != 0) begin
                room = COUNT_RANGE - counter[t];
                if (steps < room) begin
                  counter[t] = COUNT_W'(counter[t] + steps);
                  steps = 0;
                end else begin
                  steps -= room;
                  counter[t] = reload[t];
                  if (t < MASK_W) begin
                    rsp.overflow_mask[t] = 1'b1;
                    if (ctl[CTRL_IRQ_BIT]) rsp.irq_mask[t] = 1'b1;
                  end
                end
              end
            end
          end
        end
        OP_WRITE: begin
          if (tmr < TIMERS) begin
            if (req.reg_index[0] == SLOT_COUNT) begin
              reload[tmr] = req.write_data;
            end else begin
              old_ctl = control[tmr];
              control[tmr] = req.write_data;
              if (!old_ctl[CTRL_ENABLE_BIT] && req.write_data[CTRL_ENABLE_BIT]) begin
                counter[tmr]      = reload[tmr];
                prescale_acc[tmr] = '0;
              end
            end
          end
        end
        OP_READ: begin
          if (tmr < TIMERS)
            rsp.read_data = (req.reg_index[0] == SLOT_CTRL) ? control[tmr] : counter[tmr];
        end
        default: ;
      endcase
      owed_responses.push_back(rsp);
    endfunction

    task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("ERROR: response %0d %s: got 0x%h, expected 0x%h",
               response_index, what, got, want);
      mismatch_count++;
    endtask

    task check_response(out_item_t got);
      out_item_t want;
      response_index++;
      if (owed_responses.size() == 0) begin
        report_mismatch("arrived with nothing owed, read_data", got.read_data, '0);
      end else begin
        want = owed_responses.pop_front();
        if (got.read_data !== want.read_data)
          report_mismatch("read_data", got.read_data, want.read_data);
        if (got.overflow_mask !== want.overflow_mask)
          report_mismatch("overflow_mask", 16'(got.overflow_mask), 16'(want.overflow_mask));
        if (got.irq_mask !== want.irq_mask)
          report_mismatch("irq_mask", 16'(got.irq_mask), 16'(want.irq_mask));
      end
    endtask
  endclass

  // Every input has a known value from time zero.
  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  timer_result_board results = new();

  // Throttling knobs, in percent per cycle; the main sequence sets them per phase.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned idle_plan  [4] = '{0, 79, 0, 31};
  int unsigned stall_plan [4] = '{0, 0, 79, 31};

  four_channel_reload_timer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver decides afresh every cycle whether it can take a response.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Both handshakes are sampled at the edge, before any driver update lands, so
  // the shadow sees requests and responses in exactly the order the block does.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) results.note_request(in_data);
      if (out_valid && out_ready) results.check_response(out_data);
    end
  end

  // Watchdog: a long run of cycles with no handshake on either side means the
  // block has hung or is holding back a response that is owed.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic in_item_t make_req(op_t op, logic [2:0] idx, logic [15:0] data);
    in_item_t req;
    req.op         = op;
    req.reg_index  = idx;
    req.write_data = data;
    return req;
  endfunction

  function automatic logic [2:0] slot(int unsigned tmr, logic kind);
    return 3'(tmr * 2 + kind);
  endfunction

  function automatic logic [15:0] ctrl_value(logic enable, logic irq_en, logic cascade,
                                             psc_sel_t psc);
    logic [15:0] w;
    w = '0;
    w[CTRL_ENABLE_BIT]  = enable;
    w[CTRL_IRQ_BIT]     = irq_en;
    w[CTRL_CASCADE_BIT] = cascade;
    w[1:0]              = psc;
    return w;
  endfunction

  // Reload values mostly sit just under the top so that overflows come often.
  function automatic logic [15:0] pick_reload();
    if ($urandom_range(3) != 0) return 16'($urandom_range(16'hFFFF, 16'hFF80));
    return 16'($urandom);
  endfunction

  // Present one request and hold it until the block takes it. Valid is lowered
  // only during a random idle stretch, never within the step that raises it.
  task automatic send_request(in_item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and wait until every owed response has come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results.owed_responses.size() != 0);
  endtask

  // Random traffic built mostly from well-formed timer programming sequences:
  // tick bursts, reload and control writes, reads, and the divisor-switch
  // sequence that lets a built-up prescale count spill into several steps.
  task automatic run_random(int unsigned n);
    int unsigned       sent, pick, burst, tmr;
    logic [15:0]       ctl;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      tmr  = $urandom_range(TIMERS - 1);
      if (pick < 50) begin
        burst = $urandom_range(20, 1);
        repeat (burst) send_request(make_req(OP_TICK, 3'($urandom), 16'($urandom)));
        sent += burst;
      end else if (pick < 63) begin
        send_request(make_req(OP_WRITE, slot(tmr, SLOT_COUNT), pick_reload()));
        sent++;
      end else if (pick < 76) begin
        ctl = 16'($urandom);
        ctl[CTRL_ENABLE_BIT]  = ($urandom_range(9) < 8);
        ctl[CTRL_CASCADE_BIT] = ($urandom_range(9) == 0);
        if ($urandom_range(1) != 0) ctl[1:0] = PSC_1;
        send_request(make_req(OP_WRITE, slot(tmr, SLOT_CTRL), ctl));
        sent++;
      end else if (pick < 84) begin
        send_request(make_req(OP_WRITE, slot(tmr, SLOT_COUNT),
                              16'($urandom_range(16'hFFFF, 16'hFFF0))));
        send_request(make_req(OP_WRITE, slot(tmr, SLOT_CTRL),
                              ctrl_value(1'b1, 1'($urandom), 1'b0, PSC_1024)));
        burst = $urandom_range(40, 1);
        repeat (burst) send_request(make_req(OP_TICK, 3'($urandom), 16'($urandom)));
        send_request(make_req(OP_WRITE, slot(tmr, SLOT_CTRL),
                              ctrl_value(1'b1, 1'($urandom), 1'b0,
                                         psc_sel_t'($urandom_range(2)))));
        send_request(make_req(OP_TICK, 3'($urandom), 16'($urandom)));
        send_request(make_req(OP_READ, slot(tmr, SLOT_COUNT), 16'($urandom)));
        sent += burst + 5;
      end else if (pick < 97) begin
        send_request(make_req(OP_READ, 3'($urandom), 16'($urandom)));
        sent++;
      end else begin
        send_request(make_req(OP_NOP, 3'($urandom), 16'($urandom)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening. Reloads at the extremes, then control words that
    // cover interrupt on and off, a cascaded timer and the slowest divisor.
    send_request(make_req(OP_WRITE, slot(0, SLOT_COUNT), 16'hFFFE));
    send_request(make_req(OP_WRITE, slot(1, SLOT_COUNT), 16'hFFFF));
    send_request(make_req(OP_WRITE, slot(2, SLOT_COUNT), 16'h0000));
    send_request(make_req(OP_WRITE, slot(3, SLOT_COUNT), 16'hFFFE));
    send_request(make_req(OP_WRITE, slot(0, SLOT_CTRL), ctrl_value(1'b1, 1'b1, 1'b0, PSC_1)));
    send_request(make_req(OP_WRITE, slot(1, SLOT_CTRL), ctrl_value(1'b1, 1'b0, 1'b0, PSC_1)));
    // Every control bit set: enabled but cascaded, so timer two must stay still.
    send_request(make_req(OP_WRITE, slot(2, SLOT_CTRL), 16'hFFFF));
    send_request(make_req(OP_WRITE, slot(3, SLOT_CTRL),
                          ctrl_value(1'b1, 1'b1, 1'b0, PSC_1024)));
    // Timer zero wraps on the second tick, timer one on every tick.
    repeat (3) send_request(make_req(OP_TICK, 3'd0, 16'h0000));
    send_request(make_req(OP_READ, slot(0, SLOT_COUNT), 16'h0000));
    send_request(make_req(OP_READ, slot(0, SLOT_CTRL), 16'h0000));
    send_request(make_req(OP_READ, slot(2, SLOT_CTRL), 16'h0000));
    // A no-op with every other bit high must change nothing and return zero.
    send_request(make_req(OP_NOP, 3'd7, 16'hFFFF));
    // Timer three has built up a prescale count of three; switching it to the
    // fastest divisor while running turns four steps into a double wrap.
    send_request(make_req(OP_WRITE, slot(3, SLOT_CTRL), ctrl_value(1'b1, 1'b1, 1'b0, PSC_1)));
    send_request(make_req(OP_TICK, 3'd0, 16'h0000));
    send_request(make_req(OP_READ, slot(3, SLOT_COUNT), 16'h0000));
    send_request(make_req(OP_READ, slot(2, SLOT_COUNT), 16'h0000));
    send_request(make_req(OP_WRITE, slot(1, SLOT_CTRL), 16'h0000));
    send_request(make_req(OP_TICK, 3'd0, 16'h0000));
    send_request(make_req(OP_READ, slot(1, SLOT_CTRL), 16'h0000));

    // Random phases with different throttling. Between phases the sender
    // holds off until everything owed has come back.
    for (int p = 0; p < 4; p++) begin
      hold_until_drained();
      send_idle_pct  = idle_plan[p];
      recv_stall_pct = stall_plan[p];
      run_random(PHASE_ITEMS);
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (results.mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/frt_pkg.sv
rtl/frt_timer.sv
rtl/four_channel_reload_timer.sv
rtl/frt_checker.sv
tb/sv/four_channel_reload_timer_test.sv
